// ===== rtl/core/sha_pkg.sv =====
// SHA-256 package: round constants, initial hash values and the queue entry type.
// Used by every module of the SHA-256 stream hasher; depends on nothing.
`timescale 1ns / 1ps
package sha_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int LENGTH_POS  = 56;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int QUEUE_DEPTH = 4;

    // Kind of work the back end does for one queued word.
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       is_end;
    } cmd_t;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        begin
            case (idx)
                6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
                6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
                6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
                6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
                6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
                6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] initial_h(input logic [2:0] idx);
        logic [31:0] h;
        begin
            case (idx)
                3'd0: h = 32'h6a09e667;
                3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372;
                3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f;
                3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab;
                3'd7: h = 32'h5be0cd19;
                default: h = 32'h0;
            endcase
            return h;
        end
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== rtl/core/sha_front.sv =====
// SHA-256 front end: accepts input words, drops empty ones, queues the rest.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    data_byte,
    input  logic          byte_valid,
    input  logic          end_of_message,
    input  logic          valid,
    output logic          stall,
    output sha_pkg::cmd_t cmd,
    output logic          cmd_valid,
    input  logic          cmd_take
);
    import sha_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    cmd_t          queue_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic          push;
    logic          pop;

    assign stall     = (count_reg == (PW+1)'(QUEUE_DEPTH));
    // A word with neither flag set changes nothing, so it is not queued.
    assign push      = valid && !stall && (byte_valid || end_of_message);
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_valid && cmd_take;
    assign cmd       = queue_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= '{data: data_byte, has_byte: byte_valid,
                                       is_end: end_of_message};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

// ===== rtl/core/sha_back.sv =====
// SHA-256 back end: block buffer, padding sequencer, 64-round compression, digest out.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_back (
    input  logic          clk,
    input  logic          rst_n,
    input  sha_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_take,
    output logic [31:0]   digest_word,
    output logic [2:0]    word_index,
    output logic          last_word,
    output logic          valid,
    input  logic          stall
);
    import sha_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [63:0] len_reg;
    logic        ending_reg;
    logic        pad_done_reg;
    // Set once the length bytes went into the block being compressed.
    logic        length_in_reg;
    // Set when the length field belongs in the block now being padded.
    logic        len_here_reg;
    logic [5:0]  round_reg;
    logic [2:0]  out_idx_reg;

    logic [7:0]  put_byte;
    logic        put_en;
    logic [31:0] w_cur, w_new, s0, s1, t1, t2;
    logic        out_fire;

    assign out_fire = valid && !stall;
    assign cmd_take = (state_reg == ST_IDLE) && cmd_valid;

    // Byte written into the block during idle or padding.
    always_comb
    begin
        put_en   = 1'b0;
        put_byte = cmd.data;
        if (state_reg == ST_IDLE && cmd_valid && cmd.has_byte)
            put_en = 1'b1;
        else if (state_reg == ST_PAD)
        begin
            put_en = 1'b1;
            if (!pad_done_reg)
                put_byte = PAD_BYTE;
            else if (fill_reg < 6'(LENGTH_POS) || !len_here_reg)
                put_byte = 8'h00;
            else
                put_byte = len_reg[8*(7 - (fill_reg - 6'(LENGTH_POS))) +: 8];
        end
    end

    // Schedule: w_reg is a sliding window, w_reg[0] is W[t].
    assign w_cur = w_reg[0];
    assign s0 = ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign w_new = w_reg[0] + s0 + w_reg[9] + s1;

    assign t1 = v_reg[7] + (ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25))
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + round_k(round_reg) + w_cur;
    assign t2 = (ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22))
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.has_byte && fill_reg == 6'd63)
                        state_next = ST_ROUND;
                    else if (cmd.is_end)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (fill_reg == 6'd63)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_reg == 6'd63)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                // A block compressed mid-padding goes back to padding, not to output.
                if (!ending_reg)
                    state_next = ST_IDLE;
                else if (length_in_reg)
                    state_next = ST_OUT;
                else
                    state_next = ST_PAD;
            end
            ST_OUT:
            begin
                if (out_fire && out_idx_reg == 3'd7)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (put_en)
        begin
            w_reg[fill_reg[5:2]][8*(3 - fill_reg[1:0]) +: 8] <= put_byte;
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
        end
        if (state_reg == ST_IDLE && cmd_valid && cmd.is_end)
            len_reg <= bits_reg + (cmd.has_byte ? 64'd8 : 64'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            bits_reg      <= '0;
            ending_reg    <= 1'b0;
            pad_done_reg  <= 1'b0;
            length_in_reg <= 1'b0;
            len_here_reg  <= 1'b0;
            round_reg     <= '0;
            out_idx_reg   <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= initial_h(3'(i));
                v_reg[i] <= initial_h(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            if (put_en)
                fill_reg <= fill_reg + 6'd1;
            if (state_reg == ST_PAD)
            begin
                pad_done_reg <= 1'b1;
                // The length fits behind the pad byte only if the pad lands
                // before the length position; otherwise it goes in the next block.
                if (!pad_done_reg)
                    len_here_reg <= (fill_reg < 6'(LENGTH_POS));
                if (fill_reg == 6'd63)
                    length_in_reg <= pad_done_reg && len_here_reg;
            end
            if (state_reg == ST_IDLE && cmd_valid)
            begin
                if (cmd.has_byte)
                    bits_reg <= bits_reg + 64'd8;
                ending_reg <= cmd.is_end;
                if (cmd.is_end)
                begin
                    pad_done_reg  <= 1'b0;
                    length_in_reg <= 1'b0;
                end
            end
            if (state_next == ST_ROUND && state_reg != ST_ROUND)
            begin
                round_reg <= '0;
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[i];
            end
            if (state_reg == ST_ROUND)
            begin
                round_reg <= round_reg + 6'd1;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
            end
            if (state_reg == ST_ADD)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
                if (ending_reg && !length_in_reg)
                    len_here_reg <= 1'b1;
            end
            if (state_reg == ST_OUT && out_fire)
            begin
                out_idx_reg <= out_idx_reg + 3'd1;
                if (out_idx_reg == 3'd7)
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= initial_h(3'(i));
                    bits_reg   <= '0;
                    fill_reg   <= '0;
                    ending_reg <= 1'b0;
                end
            end
        end
    end

    assign valid       = (state_reg == ST_OUT);
    assign digest_word = h_reg[out_idx_reg];
    assign word_index  = out_idx_reg;
    assign last_word   = (out_idx_reg == 3'd7);

endmodule

// ===== rtl/core/sha256_stream_hash.sv =====
// SHA-256 stream hasher top level: joins the front queue and the compression back end.
// Depends on sha_pkg, sha_front and sha_back.
`timescale 1ns / 1ps
//  Channel | Handshake          | Fields
//  input   | in_valid/in_stall  | data_byte, byte_valid, end_of_message
//  output  | out_valid/out_stall| digest_word, word_index, last_word
//
// A byte word is written into the block buffer; the 64th byte of a block also
// starts a compression: the rounds, run by the single shared round unit, and
// after them the chaining add. An end word adds the padding bytes, one or two
// block compressions, and the eight digest words on the output.
// Reset clears the chaining words to the initial hash values and empties the
// queue. The four-entry queue keeps taking words, until it is full, while the
// back end is busy or while a digest word waits on out_stall.
module sha256_stream_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_take;

    sha_front u_front (
        .clk(clk), .rst_n(rst_n),
        .data_byte(data_byte), .byte_valid(byte_valid),
        .end_of_message(end_of_message),
        .valid(in_valid), .stall(in_stall),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
    );

    sha_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word),
        .valid(out_valid), .stall(out_stall)
    );

    // The last-word flag marks exactly index seven.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last_word out of step with word_index");

    // Digest words come out in order: a taken word that is not last is
    // followed by the next index.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_word) |=> (out_valid &&
            word_index == $past(word_index) + 3'd1))
        else $error("digest words out of order");

    // A stalled digest word holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(digest_word)))
        else $error("stalled digest word changed");

endmodule
